FILE: hdl/clt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package clt_pkg;

  localparam int unsigned MaxLineDef = 256;

  localparam logic [7:0] EolCh    = 8'h00;
  localparam logic [7:0] QuoteCh  = 8'h22;
  localparam logic [7:0] SpaceCh  = 8'h20;

  localparam logic [7:0] MaxArgsRst = 8'd16;

  localparam logic KindToken   = 1'b0;
  localparam logic KindSummary = 1'b1;

  // result queue
  localparam int unsigned ResDepth = 4;
  localparam int unsigned ResPtrW  = 2;
  localparam int unsigned ResCntW  = 3;

  typedef struct packed {
    logic       kind;
    logic [8:0] token_start;
    logic [8:0] token_length;
    logic [7:0] token_number;
    logic [7:0] arg_count;
    logic       last_of_run;
  } res_t;

  typedef struct packed {
    logic has_candidate;
    logic at_token_start;
    logic in_quotes;
    logic after_quote;
  } tok_flags_t;

  // how many results one byte pushes into the queue
  typedef struct packed {
    logic push0;
    logic push1;
  } res_push_t;

endpackage

`default_nettype wire

FILE: hdl/clt_step.sv
`timescale 1ns / 1ps
`default_nettype none

module clt_step #(
  parameter int unsigned MaxLine = clt_pkg::MaxLineDef,
  parameter int unsigned PosW    = $clog2(MaxLine + 1)
) (
  input  logic [7:0]           ch_i,
  input  logic [7:0]           max_args_i,
  input  logic [PosW-1:0]      position_i,
  input  logic [PosW-1:0]      cand_start_i,
  input  clt_pkg::tok_flags_t  flags_i,
  input  logic [7:0]           token_count_i,
  output logic [PosW-1:0]      position_o,
  output logic [PosW-1:0]      cand_start_o,
  output clt_pkg::tok_flags_t  flags_o,
  output logic [7:0]           token_count_o,
  output clt_pkg::res_push_t   push_o,
  output clt_pkg::res_t        res0_o,
  output clt_pkg::res_t        res1_o
);
  import clt_pkg::*;

  localparam logic [PosW-1:0] PosMax = PosW'(MaxLine);

  logic            is_eol;
  logic            is_quote;
  logic            is_space;
  logic            may_close;
  logic            tok_ok;
  logic [PosW:0]   start_w;
  logic [PosW-1:0] start_sat;
  logic [PosW-1:0] end_pos;
  logic [PosW-1:0] len;
  logic [31:0]     start_ext;
  logic [31:0]     len_ext;
  logic [7:0]      count_inc;
  res_t            tok_res;
  res_t            sum_res;

  assign is_eol    = (ch_i == EolCh);
  assign is_quote  = (ch_i == QuoteCh);
  assign is_space  = (ch_i == SpaceCh);
  // an open quoted token closes only right after its closing quote
  assign may_close = !flags_i.in_quotes || flags_i.after_quote;
  assign tok_ok    = flags_i.has_candidate && (token_count_i < max_args_i);
  assign count_inc = token_count_i + 8'd1;

  always_comb begin
    start_w   = {1'b0, cand_start_i} + {{PosW{1'b0}}, flags_i.in_quotes};
    start_sat = (start_w > {1'b0, PosMax}) ? PosMax : start_w[PosW-1:0];
    end_pos   = (flags_i.after_quote && (position_i != '0)) ? position_i - 1'b1
                                                            : position_i;
    len       = (end_pos > start_sat) ? end_pos - start_sat : '0;
    start_ext = 32'(start_sat);
    len_ext   = 32'(len);
  end

  always_comb begin
    tok_res.kind         = KindToken;
    tok_res.token_start  = start_ext[8:0];
    tok_res.token_length = len_ext[8:0];
    tok_res.token_number = token_count_i;
    tok_res.arg_count    = count_inc;
    tok_res.last_of_run  = !is_eol;

    sum_res.kind         = KindSummary;
    sum_res.token_start  = '0;
    sum_res.token_length = '0;
    sum_res.token_number = '0;
    sum_res.arg_count    = (may_close && tok_ok) ? count_inc : token_count_i;
    sum_res.last_of_run  = 1'b1;
  end

  always_comb begin
    position_o    = (position_i < PosMax) ? position_i + 1'b1 : position_i;
    cand_start_o  = cand_start_i;
    flags_o       = flags_i;
    token_count_o = token_count_i;
    push_o        = '0;
    res0_o        = tok_res;
    res1_o        = sum_res;

    if (is_eol) begin
      position_o    = '0;
      cand_start_o  = '0;
      flags_o       = '{has_candidate: 1'b0, at_token_start: 1'b1,
                        in_quotes: 1'b0, after_quote: 1'b0};
      token_count_o = '0;
      push_o.push0  = 1'b1;
      if (may_close && tok_ok) begin
        push_o.push1 = 1'b1;
      end else begin
        res0_o = sum_res;
      end
    end else if (is_quote) begin
      if (flags_i.at_token_start) begin
        flags_o.in_quotes     = 1'b1;
        flags_o.has_candidate = 1'b1;
        cand_start_o          = position_i;
      end
      flags_o.at_token_start = 1'b0;
      flags_o.after_quote    = 1'b1;
    end else if (is_space) begin
      if (may_close) begin
        flags_o.has_candidate  = 1'b0;
        flags_o.in_quotes      = 1'b0;
        flags_o.at_token_start = 1'b1;
        if (tok_ok) begin
          push_o.push0  = 1'b1;
          token_count_o = count_inc;
        end
      end
      flags_o.after_quote = 1'b0;
    end else begin
      if (!flags_i.has_candidate) begin
        flags_o.has_candidate = 1'b1;
        cand_start_o          = position_i;
      end
      flags_o.at_token_start = 1'b0;
      flags_o.after_quote    = 1'b0;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/clt_res_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module clt_res_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  clt_pkg::res_push_t  push_i,
  input  clt_pkg::res_t       res0_i,
  input  clt_pkg::res_t       res1_i,
  output logic                room2_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output clt_pkg::res_t       res_o
);
  import clt_pkg::*;

  res_t               mem_q [ResDepth];
  logic [ResPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [ResPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [ResCntW-1:0] cnt_q, cnt_d;
  logic [ResPtrW-1:0] wr_ptr_nx;
  logic               pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign res_o       = mem_q[rd_ptr_q];
  // registered count only, so ready never depends on the output side this cycle
  assign room2_o     = (cnt_q <= ResCntW'(ResDepth - 2));
  assign wr_ptr_nx   = wr_ptr_q + 1'b1;

  always_comb begin
    wr_ptr_d = wr_ptr_q + ResPtrW'(push_i.push0) + ResPtrW'(push_i.push1);
    rd_ptr_d = rd_ptr_q + ResPtrW'(pop);
    cnt_d    = cnt_q + ResCntW'(push_i.push0) + ResCntW'(push_i.push1)
               - ResCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push0) begin
      mem_q[wr_ptr_q] <= res0_i;
    end
    if (push_i.push1) begin
      mem_q[wr_ptr_nx] <= res1_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= ResCntW'(ResDepth))
    else $error("result queue over depth");

  a_no_push_when_tight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !room2_o |-> !push_i.push0)
    else $error("push into result queue without room");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ResPtrW'(wr_ptr_q - rd_ptr_q) == cnt_q[ResPtrW-1:0])
    else $error("result queue pointers disagree with count");

endmodule

`default_nettype wire

FILE: hdl/command_line_tokenizer_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Command line tokenizer: takes one line byte per cycle (a zero byte ends the
// line) and reports each space-separated or quoted token, up to max_args of
// them, as it closes, with its start offset, length and number, then a summary
// with the token count at the end of the line. A byte is taken every cycle
// while the output keeps up; a byte that closes a token emits at most one
// result, an end-of-line byte emits one or two. Results go through a
// four-entry queue that drains one per cycle while out_ready_i is high, and
// in_ready_o is high whenever at least two entries are free. max_args should
// be written only between items.
module command_line_tokenizer_core #(
  parameter int unsigned MaxLine = clt_pkg::MaxLineDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       max_args_we_i,
  input  logic [7:0] max_args_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] ch_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       kind_o,
  output logic [8:0] token_start_o,
  output logic [8:0] token_length_o,
  output logic [7:0] token_number_o,
  output logic [7:0] arg_count_o,
  output logic       last_of_run_o
);
  import clt_pkg::*;

  localparam int unsigned PosW = $clog2(MaxLine + 1);

  logic [7:0]      max_args_q;
  logic [PosW-1:0] position_q, position_d;
  logic [PosW-1:0] cand_start_q, cand_start_d;
  tok_flags_t      flags_q, flags_d;
  logic [7:0]      token_count_q, token_count_d;
  res_push_t       step_push;
  res_push_t       push;
  res_t            res0;
  res_t            res1;
  res_t            res_out;
  logic            room2;
  logic            in_fire;

  assign in_ready_o = room2;
  assign in_fire    = in_valid_i && in_ready_o;
  assign push       = in_fire ? step_push : '0;

  clt_step #(
    .MaxLine (MaxLine),
    .PosW    (PosW)
  ) u_step (
    .ch_i          (ch_i),
    .max_args_i    (max_args_q),
    .position_i    (position_q),
    .cand_start_i  (cand_start_q),
    .flags_i       (flags_q),
    .token_count_i (token_count_q),
    .position_o    (position_d),
    .cand_start_o  (cand_start_d),
    .flags_o       (flags_d),
    .token_count_o (token_count_d),
    .push_o        (step_push),
    .res0_o        (res0),
    .res1_o        (res1)
  );

  clt_res_fifo u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .res0_i      (res0),
    .res1_i      (res1),
    .room2_o     (room2),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_out)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_args_q    <= MaxArgsRst;
      position_q    <= '0;
      cand_start_q  <= '0;
      flags_q       <= '{has_candidate: 1'b0, at_token_start: 1'b1,
                         in_quotes: 1'b0, after_quote: 1'b0};
      token_count_q <= '0;
    end else begin
      if (max_args_we_i) begin
        max_args_q <= max_args_i;
      end
      if (in_fire) begin
        position_q    <= position_d;
        cand_start_q  <= cand_start_d;
        flags_q       <= flags_d;
        token_count_q <= token_count_d;
      end
    end
  end

  assign kind_o         = res_out.kind;
  assign token_start_o  = res_out.token_start;
  assign token_length_o = res_out.token_length;
  assign token_number_o = res_out.token_number;
  assign arg_count_o    = res_out.arg_count;
  assign last_of_run_o  = res_out.last_of_run;

  a_eol_clears_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && ch_i == EolCh) |=> (position_q == '0 && token_count_q == '0))
    else $error("line state not cleared after end of line");

  a_quote_needs_candidate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flags_q.in_quotes |-> flags_q.has_candidate)
    else $error("quoted token open without a candidate");

  a_summary_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KindSummary) |-> last_of_run_o)
    else $error("summary not marked last of run");

  a_pos_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    position_q <= PosW'(MaxLine))
    else $error("line position beyond saturation");

endmodule

`default_nettype wire

FILE: sim/command_line_tokenizer_core_tb.sv
`timescale 1ns / 1ps

module command_line_tokenizer_core_tb;
  import clt_pkg::*;

  localparam int unsigned LineMax = MaxLineDef;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       max_args_we_i = 1'b0;
  logic [7:0] max_args_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] ch_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic       kind_o;
  logic [8:0] token_start_o;
  logic [8:0] token_length_o;
  logic [7:0] token_number_o;
  logic [7:0] arg_count_o;
  logic       last_of_run_o;

  bit no_idle = 1'b0;
  bit hold_req = 1'b0;
  logic [7:0] line_q[$];

  command_line_tokenizer_core #(
    .MaxLine(LineMax)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .max_args_we_i (max_args_we_i),
    .max_args_i    (max_args_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .ch_i          (ch_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .token_start_o (token_start_o),
    .token_length_o(token_length_o),
    .token_number_o(token_number_o),
    .arg_count_o   (arg_count_o),
    .last_of_run_o (last_of_run_o)
  );

  class token_scoreboard;
    logic [7:0]  max_args;
    int unsigned line_pos;
    int unsigned tok_begin;
    int unsigned tok_count;
    bit          has_tok;
    bit          tok_edge;
    bit          in_q;
    bit          after_q;
    res_t        step_q[$];
    res_t        expected_q[$];
    int unsigned errors;

    function new();
      max_args = MaxArgsRst;
      errors = 0;
      clear_line();
    endfunction

    function void clear_line();
      line_pos = 0;
      has_tok = 1'b0;
      tok_begin = 0;
      tok_edge = 1'b1;
      in_q = 1'b0;
      after_q = 1'b0;
      tok_count = 0;
    endfunction

    function void set_max_args(logic [7:0] v);
      max_args = v;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void push_step(logic k, int unsigned s, int unsigned l, int unsigned num,
                            int unsigned cnt);
      res_t r;
      r.kind = k;
      r.token_start = 9'(s);
      r.token_length = 9'(l);
      r.token_number = 8'(num);
      r.arg_count = 8'(cnt);
      r.last_of_run = 1'b0;
      step_q.push_back(r);
    endfunction

    function void close_token();
      int unsigned stop;
      int unsigned first;
      int unsigned len;
      stop = line_pos;
      // a quote just before the closing byte is not part of the token
      if (after_q && stop > 0) stop--;
      if (has_tok) begin
        first = tok_begin + (in_q ? 1 : 0);
        if (first > LineMax) first = LineMax;
        len = (stop > first) ? stop - first : 0;
        if (tok_count < max_args) begin
          push_step(KindToken, first, len, tok_count, tok_count + 1);
          tok_count = (tok_count + 1) & 8'hFF;
        end
      end
      has_tok = 1'b0;
    endfunction

    function void note_input(logic [7:0] c);
      step_q.delete();
      if (c == EolCh) begin
        if (!in_q || after_q) close_token();
        push_step(KindSummary, 0, 0, 0, tok_count);
        clear_line();
      end else begin
        if (c == QuoteCh) begin
          if (tok_edge) begin
            in_q = 1'b1;
            has_tok = 1'b1;
            tok_begin = line_pos;
          end
          tok_edge = 1'b0;
          after_q = 1'b1;
        end else if (c == SpaceCh) begin
          if (!in_q || after_q) begin
            close_token();
            in_q = 1'b0;
            tok_edge = 1'b1;
          end
          after_q = 1'b0;
        end else begin
          if (!has_tok) begin
            has_tok = 1'b1;
            tok_begin = line_pos;
          end
          tok_edge = 1'b0;
          after_q = 1'b0;
        end
        if (line_pos < LineMax) line_pos++;
      end
      if (step_q.size() > 0) step_q[step_q.size() - 1].last_of_run = 1'b1;
      foreach (step_q[i]) expected_q.push_back(step_q[i]);
    endfunction

    function void compare(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: kind %0d, arg_count %0d",
               got.kind, got.arg_count);
        errors++;
      end else begin
        want = expected_q.pop_front();
        compare("kind", want.kind, got.kind);
        compare("token_start", want.token_start, got.token_start);
        compare("token_length", want.token_length, got.token_length);
        compare("token_number", want.token_number, got.token_number);
        compare("arg_count", want.arg_count, got.arg_count);
        compare("last_of_run", want.last_of_run, got.last_of_run);
      end
    endfunction
  endclass

  token_scoreboard sb = new();

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [7:0] token_byte();
    if ($urandom_range(0, 4) == 0) return 8'($urandom_range(1, 255));
    return 8'($urandom_range(8'h61, 8'h7A));
  endfunction

  // appends one line without its terminator to line_q
  function automatic void build_line(int unsigned min_len);
    int unsigned ntok;
    int unsigned nch;
    if (min_len == 0 && $urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 12)) line_q.push_back(8'($urandom_range(1, 255)));
    end else begin
      ntok = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) : $urandom_range(0, 5);
      if ($urandom_range(0, 3) == 0) line_q.push_back(SpaceCh);
      for (int t = 0; t < ntok || line_q.size() < min_len; t++) begin
        if (t > 0) repeat ($urandom_range(1, 2)) line_q.push_back(SpaceCh);
        nch = $urandom_range(0, 4);
        case ($urandom_range(0, 9))
          6, 7: begin
            line_q.push_back(QuoteCh);
            repeat (nch) line_q.push_back(($urandom_range(0, 3) == 0) ? SpaceCh : token_byte());
            // sometimes leave the quote open
            if ($urandom_range(0, 5) != 0) line_q.push_back(QuoteCh);
          end
          8: line_q.push_back(QuoteCh);
          9: begin
            repeat (nch) line_q.push_back(token_byte());
            line_q.push_back(QuoteCh);
            if ($urandom_range(0, 1) == 1) line_q.push_back(token_byte());
          end
          default: repeat (nch + 1) line_q.push_back(token_byte());
        endcase
      end
      if ($urandom_range(0, 3) == 0) line_q.push_back(SpaceCh);
    end
  endfunction

  task automatic send_byte(logic [7:0] c);
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    ch_i <= c;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_input(c);
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_byte(line_q[i]);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_max_args(logic [7:0] v);
    max_args_we_i <= 1'b1;
    max_args_i <= v;
    @(posedge clk_i);
    max_args_we_i <= 1'b0;
    sb.set_max_args(v);
  endtask

  initial begin : result_sink
    res_t got;
    int unsigned stall_left;
    bit long_done;
    stall_left = 0;
    long_done = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got.kind = kind_o;
        got.token_start = token_start_o;
        got.token_length = token_length_o;
        got.token_number = token_number_o;
        got.arg_count = arg_count_o;
        got.last_of_run = last_of_run_o;
        sb.check_result(got);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (hold_req && !long_done) begin
        // long back-pressure so the result queue fills and the input stalls
        long_done = 1'b1;
        stall_left = 79;
        out_ready_i <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic [7:0] cfg_plan[6];
    int unsigned sent;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    line_q = {8'h01, SpaceCh, 8'hFF, EolCh,
              EolCh,
              QuoteCh, 8'h61, SpaceCh, 8'h62, QuoteCh, EolCh,
              QuoteCh, SpaceCh, EolCh,
              QuoteCh, 8'h61, EolCh,
              8'h61, QuoteCh, SpaceCh, EolCh};
    send_line();

    cfg_plan = '{8'd0, 8'd1, 8'd255, 8'd2, 8'($urandom_range(3, 254)), 8'd255};
    foreach (cfg_plan[p]) begin
      drain();
      write_max_args(cfg_plan[p]);
      if (p == 5) no_idle = 1'b1;
      if (p == 2) begin
        hold_req = 1'b1;
        // line past the saturation point, with a quoted token and then a plain one there
        line_q.delete();
        build_line(LineMax + 2);
        line_q = {line_q, SpaceCh, QuoteCh, 8'h78, QuoteCh, SpaceCh, 8'h79, EolCh};
        send_line();
      end
      sent = 0;
      while (sent < 50) begin
        line_q.delete();
        build_line(0);
        line_q.push_back(EolCh);
        sent += line_q.size();
        send_line();
      end
    end
    drain();

    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #1_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
